/* hdl/query_text_tokenizer_unit_macros.svh */
// assertion macros shared by the query text tokenizer modules
`ifndef QUERY_TEXT_TOKENIZER_UNIT_MACROS_SVH
`define QUERY_TEXT_TOKENIZER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define QTT_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("tokenizer assertion failed");

// next-cycle implication, checked out of reset
`define QTT_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("tokenizer assertion failed");

`endif

/* hdl/qtt_pkg.sv */
// types and constants of the query text tokenizer
package qtt_pkg;

    // one request on the text channel
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } text_item_t;

    // one token on the result channel
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] start_offset;
        logic [15:0] text_length;
        logic        run_last;
    } token_item_t;

    // tokens produced by one text byte, first one emitted first
    typedef struct packed {
        logic [1:0]  count;
        token_item_t first;
        token_item_t second;
    } lex_result_t;

    // lexing mode
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_IDENT  = 2'd3
    } lex_mode_t;

    // token kinds
    localparam logic [3:0] KIND_LBRACE  = 4'd0;
    localparam logic [3:0] KIND_RBRACE  = 4'd1;
    localparam logic [3:0] KIND_LPAREN  = 4'd2;
    localparam logic [3:0] KIND_RPAREN  = 4'd3;
    localparam logic [3:0] KIND_COLON   = 4'd4;
    localparam logic [3:0] KIND_COMMA   = 4'd5;
    localparam logic [3:0] KIND_STRING  = 4'd6;
    localparam logic [3:0] KIND_NUMBER  = 4'd7;
    localparam logic [3:0] KIND_IDENT   = 4'd8;
    localparam logic [3:0] KIND_INVALID = 4'd9;

    // character codes
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_UNDER  = 8'h5F;

    // token queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

/* hdl/qtt_lexer.sv */
// lexer state and single-pass byte classification
`include "query_text_tokenizer_unit_macros.svh"

module qtt_lexer #(
    parameter int POSITION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  qtt_pkg::text_item_t item,
    output qtt_pkg::lex_result_t result
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam int SPAN_W = POSITION_BITS + 1;
    localparam int EXT_W  = (SPAN_W > 17) ? SPAN_W : 17;

    qtt_pkg::lex_mode_t         mode_reg, mode_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;
    logic [POSITION_BITS-1:0]   start_reg, start_next;

    logic [7:0]                 c;
    logic                       is_digit, is_alpha, is_space, is_punct;
    logic [3:0]                 punct_kind;
    logic                       ending, closing, run_idle;
    qtt_pkg::lex_mode_t         mid_mode;
    logic [POSITION_BITS-1:0]   mid_start;
    logic [POSITION_BITS-1:0]   pos_inc;
    logic                       a_valid, b_valid, f_valid;
    qtt_pkg::token_item_t       a_tok, b_tok, f_tok;

    // saturate a span-wide value into a 16-bit field
    function automatic logic [15:0] clamp16(input logic [SPAN_W-1:0] v);
        logic [EXT_W-1:0] wide;
        wide = EXT_W'(v);
        clamp16 = (wide > EXT_W'(17'h0FFFF)) ? 16'hFFFF : wide[15:0];
    endfunction

    // distance from a start to an end, zero when the end is not past it
    function automatic logic [SPAN_W-1:0] span(input logic [POSITION_BITS-1:0] from,
                                               input logic [SPAN_W-1:0] to);
        logic [SPAN_W-1:0] fe;
        fe = {1'b0, from};
        span = (to > fe) ? (to - fe) : '0;
    endfunction

    // byte classes
    assign c        = item.text_byte;
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    assign is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    assign pos_inc  = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 1'b1;

    // punctuation lookup
    always_comb
    begin
        is_punct   = 1'b1;
        punct_kind = qtt_pkg::KIND_INVALID;
        unique case (c)
            qtt_pkg::CHAR_LBRACE: punct_kind = qtt_pkg::KIND_LBRACE;
            qtt_pkg::CHAR_RBRACE: punct_kind = qtt_pkg::KIND_RBRACE;
            qtt_pkg::CHAR_LPAREN: punct_kind = qtt_pkg::KIND_LPAREN;
            qtt_pkg::CHAR_RPAREN: punct_kind = qtt_pkg::KIND_RPAREN;
            qtt_pkg::CHAR_COLON:  punct_kind = qtt_pkg::KIND_COLON;
            qtt_pkg::CHAR_COMMA:  punct_kind = qtt_pkg::KIND_COMMA;
            default:              is_punct   = 1'b0;
        endcase
    end

    // close of the open token by this byte
    assign ending = ((mode_reg == qtt_pkg::MODE_NUMBER) && !(is_digit || c == qtt_pkg::CHAR_DOT))
                 || ((mode_reg == qtt_pkg::MODE_IDENT)
                     && !(is_alpha || is_digit || c == qtt_pkg::CHAR_UNDER));
    assign closing  = (mode_reg == qtt_pkg::MODE_STRING) && (c == qtt_pkg::CHAR_QUOTE);
    assign run_idle = (mode_reg == qtt_pkg::MODE_IDLE) || ending;

    always_comb
    begin
        // token that this byte ends
        a_valid            = ending || closing;
        a_tok.token_kind   = (mode_reg == qtt_pkg::MODE_STRING) ? qtt_pkg::KIND_STRING :
                             (mode_reg == qtt_pkg::MODE_NUMBER) ? qtt_pkg::KIND_NUMBER :
                                                                  qtt_pkg::KIND_IDENT;
        a_tok.start_offset = clamp16({1'b0, start_reg});
        a_tok.text_length  = clamp16(span(start_reg, {1'b0, pos_reg}));
        a_tok.run_last     = 1'b0;

        // byte lexed from between tokens
        mid_mode           = a_valid ? qtt_pkg::MODE_IDLE : mode_reg;
        mid_start          = start_reg;
        b_valid            = 1'b0;
        b_tok.token_kind   = qtt_pkg::KIND_INVALID;
        b_tok.start_offset = clamp16({1'b0, pos_reg});
        b_tok.text_length  = 16'd1;
        b_tok.run_last     = 1'b0;
        if (run_idle)
        begin
            priority if (is_space)
            begin
                mid_mode = qtt_pkg::MODE_IDLE;
            end
            else if (is_punct)
            begin
                b_valid          = 1'b1;
                b_tok.token_kind = punct_kind;
            end
            else if (c == qtt_pkg::CHAR_QUOTE)
            begin
                mid_mode  = qtt_pkg::MODE_STRING;
                mid_start = pos_inc;
            end
            else if (is_digit || c == qtt_pkg::CHAR_MINUS)
            begin
                mid_mode  = qtt_pkg::MODE_NUMBER;
                mid_start = pos_reg;
            end
            else if (is_alpha || c == qtt_pkg::CHAR_UNDER)
            begin
                mid_mode  = qtt_pkg::MODE_IDENT;
                mid_start = pos_reg;
            end
            else
            begin
                b_valid = 1'b1;
            end
        end

        // token flushed by the end of text
        f_valid            = item.final_byte && (mid_mode != qtt_pkg::MODE_IDLE);
        f_tok.token_kind   = (mid_mode == qtt_pkg::MODE_NUMBER) ? qtt_pkg::KIND_NUMBER :
                             (mid_mode == qtt_pkg::MODE_IDENT)  ? qtt_pkg::KIND_IDENT :
                                                                  qtt_pkg::KIND_INVALID;
        f_tok.start_offset = clamp16({1'b0, mid_start});
        f_tok.text_length  = (mid_mode == qtt_pkg::MODE_STRING) ? 16'd0 :
                             clamp16(span(mid_start, {1'b0, pos_reg} + 1'b1));
        f_tok.run_last     = 1'b0;
    end

    // pack the tokens in emission order and mark the last one
    always_comb
    begin
        result.count  = 2'(a_valid) + 2'(b_valid) + 2'(f_valid);
        result.first  = a_valid ? a_tok : (b_valid ? b_tok : f_tok);
        result.second = (a_valid && b_valid) ? b_tok : f_tok;
        if (result.count == 2'd1)
        begin
            result.first.run_last = 1'b1;
        end
        if (result.count == 2'd2)
        begin
            result.second.run_last = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        if (step)
        begin
            if (item.final_byte)
            begin
                mode_next  = qtt_pkg::MODE_IDLE;
                pos_next   = '0;
                start_next = '0;
            end
            else
            begin
                mode_next  = mid_mode;
                pos_next   = pos_inc;
                start_next = mid_start;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= qtt_pkg::MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
        end
    end

    // end of text returns to reset state
    `QTT_ASSERT_NEXT(a_final_resets, step && item.final_byte,
        mode_reg == qtt_pkg::MODE_IDLE && pos_reg == '0 && start_reg == '0)
    // position advances by one below saturation
    `QTT_ASSERT_NEXT(a_pos_advance, step && !item.final_byte && pos_reg != POS_MAX,
        pos_reg == $past(pos_reg) + 1'b1)
    // state holds without a request
    `QTT_ASSERT_NEXT(a_state_holds, !step,
        $stable(mode_reg) && $stable(pos_reg) && $stable(start_reg))

endmodule

/* hdl/qtt_token_queue.sv */
// token queue between the lexer and the result channel
`include "query_text_tokenizer_unit_macros.svh"

module qtt_token_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  qtt_pkg::lex_result_t  result,
    output logic                  room,
    output logic                  token_valid,
    input  logic                  token_ready,
    output qtt_pkg::token_item_t  token_item
);

    localparam int DEPTH = qtt_pkg::QUEUE_DEPTH;
    localparam int PW    = qtt_pkg::QPTR_W;
    localparam int CW    = qtt_pkg::QCNT_W;

    qtt_pkg::token_item_t entries_reg [DEPTH];
    logic [PW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        push_n;
    logic                 pop;
    logic [PW-1:0]        wr_ptr_second;

    // room for the two tokens a byte may give
    assign room          = count_reg <= CW'(DEPTH - 2);
    assign token_valid   = count_reg != '0;
    assign token_item    = entries_reg[rd_ptr_reg];
    assign pop           = token_valid && token_ready;
    assign push_n        = push ? CW'(result.count) : '0;
    assign wr_ptr_second = wr_ptr_reg + 1'b1;

    // pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_n);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + push_n - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // token storage
    always_ff @(posedge clk)
    begin
        if (push && result.count != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= result.first;
        end
        if (push && result.count == 2'd2)
        begin
            entries_reg[wr_ptr_second] <= result.second;
        end
    end

    // fill never exceeds the depth
    `QTT_ASSERT_NOW(a_no_overflow, 1'b1, count_reg <= CW'(DEPTH))
    // a push only lands where there is room
    `QTT_ASSERT_NOW(a_push_has_room, push, count_reg <= CW'(DEPTH - 2))
    // fill and pointers stay consistent
    `QTT_ASSERT_NEXT(a_fill_tracks, 1'b1,
        PW'(wr_ptr_reg - rd_ptr_reg) == PW'(count_reg))

endmodule

/* hdl/query_text_tokenizer_unit.sv */
// top level of the query text tokenizer
// One text byte is accepted per cycle while the queue has room. The lexer
// classifies the byte and updates its mode, position and token start in that
// same cycle, and the tokens it completes (zero, one or two) enter a
// four-entry token queue, which offers them in order on the result channel.
// The queue drains one token per cycle while token_ready is high, and the
// text channel is held off while fewer than two queue entries are free. A
// final byte flushes any open token and restarts offsets at zero for the
// next text.
module query_text_tokenizer_unit #(
    parameter int POSITION_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_ready,
    input  qtt_pkg::text_item_t  text_item,
    output logic                 token_valid,
    input  logic                 token_ready,
    output qtt_pkg::token_item_t token_item
);

    logic                 step;
    logic                 room;
    qtt_pkg::lex_result_t result;

    // accept a byte whenever the queue can take its tokens
    assign text_ready = room;
    assign step       = text_valid && room;

    // byte lexer
    qtt_lexer #(
        .POSITION_BITS(POSITION_BITS)
    ) u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (text_item),
        .result(result)
    );

    // token queue
    qtt_token_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step),
        .result     (result),
        .room       (room),
        .token_valid(token_valid),
        .token_ready(token_ready),
        .token_item (token_item)
    );

endmodule

/* test/testbench.sv */
// self-checking testbench for the query text tokenizer: random and directed text, token checks
`timescale 1ns / 1ps

module testbench;

    localparam int          RESET_CYCLES  = 5;
    localparam int          RANDOM_BYTES  = 2000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_CYCLES  = 12;
    localparam int          STALL_LIMIT   = 3000;
    localparam int          REPORT_LIMIT  = 10;
    localparam logic [15:0] POS_MAX       = 16'hFFFF;

    // character classes used by the lexer
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7A;

    // one queued text byte; settle holds it back until all tokens are out
    typedef struct {
        qtt_pkg::text_item_t item;
        bit                  settle;
    } pending_byte_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 text_valid = 1'b0;
    logic                 text_ready;
    qtt_pkg::text_item_t  text_item = '0;
    logic                 token_valid;
    logic                 token_ready = 1'b0;
    qtt_pkg::token_item_t token_item;

    pending_byte_t        text_queue[$];
    qtt_pkg::token_item_t lexed_tokens[$];

    // lexer state of the predictor
    qtt_pkg::lex_mode_t lex_state = qtt_pkg::MODE_IDLE;
    logic [15:0]        scan_pos = '0;
    logic [15:0]        open_start = '0;

    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          next_hold_at = 40;
    int          stall_cycle = 0;
    int          idle_cycles = 0;
    int          failures = 0;
    int          bytes_sent = 0;
    int          texts_ended = 0;
    int          tokens_checked = 0;
    int          saturated_tokens = 0;
    bit [15:0]   kinds_seen = '0;

    query_text_tokenizer_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_item  (text_item),
        .token_valid(token_valid),
        .token_ready(token_ready),
        .token_item (token_item)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // character classification
    function automatic bit is_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) || (c >= CHAR_UP_A && c <= CHAR_UP_Z);
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic bit punct_kind(input logic [7:0] c, output logic [3:0] kind);
        punct_kind = 1'b1;
        case (c)
            qtt_pkg::CHAR_LBRACE: kind = qtt_pkg::KIND_LBRACE;
            qtt_pkg::CHAR_RBRACE: kind = qtt_pkg::KIND_RBRACE;
            qtt_pkg::CHAR_LPAREN: kind = qtt_pkg::KIND_LPAREN;
            qtt_pkg::CHAR_RPAREN: kind = qtt_pkg::KIND_RPAREN;
            qtt_pkg::CHAR_COLON:  kind = qtt_pkg::KIND_COLON;
            qtt_pkg::CHAR_COMMA:  kind = qtt_pkg::KIND_COMMA;
            default:
            begin
                kind       = qtt_pkg::KIND_INVALID;
                punct_kind = 1'b0;
            end
        endcase
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] p);
        return (p == POS_MAX) ? p : p + 16'd1;
    endfunction

    // token length between two positions, saturating
    function automatic logic [15:0] span_len(input logic [16:0] from, input logic [16:0] upto);
        logic [16:0] diff;
        diff = (upto > from) ? upto - from : 17'd0;
        return (diff > {1'b0, POS_MAX}) ? POS_MAX : diff[15:0];
    endfunction

    function automatic qtt_pkg::token_item_t make_token(input logic [3:0] kind,
                                                        input logic [15:0] start,
                                                        input logic [15:0] len);
        qtt_pkg::token_item_t tk;
        tk.token_kind   = kind;
        tk.start_offset = start;
        tk.text_length  = len;
        tk.run_last     = 1'b0;
        return tk;
    endfunction

    // advance the lexer by one byte and queue the tokens it completes
    task automatic lex_byte(input qtt_pkg::text_item_t it);
        qtt_pkg::token_item_t toks[$];
        logic [7:0]  c;
        logic [15:0] p;
        logic [3:0]  pk;
        bit          relex;
        c     = it.text_byte;
        p     = scan_pos;
        relex = 1'b0;
        case (lex_state)
            qtt_pkg::MODE_STRING:
                if (c == qtt_pkg::CHAR_QUOTE)
                begin
                    toks.insert(toks.size(), make_token(qtt_pkg::KIND_STRING, open_start,
                                span_len({1'b0, open_start}, {1'b0, p})));
                    lex_state = qtt_pkg::MODE_IDLE;
                end
            qtt_pkg::MODE_NUMBER:
                if (!(is_digit(c) || c == qtt_pkg::CHAR_DOT))
                begin
                    toks.insert(toks.size(), make_token(qtt_pkg::KIND_NUMBER, open_start,
                                span_len({1'b0, open_start}, {1'b0, p})));
                    lex_state = qtt_pkg::MODE_IDLE;
                    relex     = 1'b1;
                end
            qtt_pkg::MODE_IDENT:
                if (!(is_alpha(c) || is_digit(c) || c == qtt_pkg::CHAR_UNDER))
                begin
                    toks.insert(toks.size(), make_token(qtt_pkg::KIND_IDENT, open_start,
                                span_len({1'b0, open_start}, {1'b0, p})));
                    lex_state = qtt_pkg::MODE_IDLE;
                    relex     = 1'b1;
                end
            default:
                relex = 1'b1;
        endcase

        // byte seen between tokens, including one that just closed a token
        if (relex && !is_space(c))
        begin
            if (punct_kind(c, pk))
                toks.insert(toks.size(), make_token(pk, p, 16'd1));
            else if (c == qtt_pkg::CHAR_QUOTE)
            begin
                lex_state  = qtt_pkg::MODE_STRING;
                open_start = sat_inc(p);
            end
            else if (is_digit(c) || c == qtt_pkg::CHAR_MINUS)
            begin
                lex_state  = qtt_pkg::MODE_NUMBER;
                open_start = p;
            end
            else if (is_alpha(c) || c == qtt_pkg::CHAR_UNDER)
            begin
                lex_state  = qtt_pkg::MODE_IDENT;
                open_start = p;
            end
            else
                toks.insert(toks.size(), make_token(qtt_pkg::KIND_INVALID, p, 16'd1));
        end

        // end of text flushes the open token and restarts offsets
        if (it.final_byte)
        begin
            case (lex_state)
                qtt_pkg::MODE_NUMBER:
                    toks.insert(toks.size(), make_token(qtt_pkg::KIND_NUMBER, open_start,
                                span_len({1'b0, open_start}, {1'b0, p} + 17'd1)));
                qtt_pkg::MODE_IDENT:
                    toks.insert(toks.size(), make_token(qtt_pkg::KIND_IDENT, open_start,
                                span_len({1'b0, open_start}, {1'b0, p} + 17'd1)));
                qtt_pkg::MODE_STRING:
                    toks.insert(toks.size(),
                                make_token(qtt_pkg::KIND_INVALID, open_start, 16'd0));
                default:
                    ;
            endcase
            lex_state  = qtt_pkg::MODE_IDLE;
            scan_pos   = '0;
            open_start = '0;
        end
        else
            scan_pos = sat_inc(p);

        if (toks.size() > 0)
            toks[toks.size() - 1].run_last = 1'b1;
        foreach (toks[i])
            lexed_tokens.insert(lexed_tokens.size(), toks[i]);
    endtask

    task automatic note_failure(input string what);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // stimulus builders
    task automatic push_byte(input logic [7:0] c, input bit last, input bit settle);
        pending_byte_t pb;
        pb.item.text_byte  = c;
        pb.item.final_byte = last;
        pb.settle          = settle;
        text_queue.insert(text_queue.size(), pb);
    endtask

    task automatic push_text(input string s, input bit ends_text);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], ends_text && i == s.len() - 1, 1'b0);
    endtask

    function automatic logic [7:0] punct_char(input int sel);
        case (sel)
            0:       return qtt_pkg::CHAR_LBRACE;
            1:       return qtt_pkg::CHAR_RBRACE;
            2:       return qtt_pkg::CHAR_LPAREN;
            3:       return qtt_pkg::CHAR_RPAREN;
            4:       return qtt_pkg::CHAR_COLON;
            default: return qtt_pkg::CHAR_COMMA;
        endcase
    endfunction

    function automatic logic [7:0] ident_char();
        int r;
        r = $urandom_range(0, 63);
        if (r < 26)
            return CHAR_LOW_A + r[7:0];
        else if (r < 52)
            return CHAR_UP_A + r[7:0] - 8'd26;
        else if (r < 62)
            return CHAR_ZERO + r[7:0] - 8'd52;
        return qtt_pkg::CHAR_UNDER;
    endfunction

    // one text built mostly from well-formed tokens, with noise and open strings
    task automatic add_random_text(input int target, input bit settle);
        logic [7:0] text_bytes[$];
        logic [7:0] c;
        int         n;
        while (text_bytes.size() < target)
        begin
            case ($urandom_range(0, 8))
                0, 1:
                    text_bytes.insert(text_bytes.size(), punct_char($urandom_range(0, 5)));
                2:
                begin
                    text_bytes.insert(text_bytes.size(), qtt_pkg::CHAR_QUOTE);
                    n = $urandom_range(0, 6);
                    repeat (n)
                    begin
                        c = 8'($urandom_range(0, 255));
                        while (c == qtt_pkg::CHAR_QUOTE)
                            c = 8'($urandom_range(0, 255));
                        text_bytes.insert(text_bytes.size(), c);
                    end
                    if ($urandom_range(0, 7) != 0)
                        text_bytes.insert(text_bytes.size(), qtt_pkg::CHAR_QUOTE);
                end
                3:
                begin
                    if ($urandom_range(0, 2) == 0)
                        text_bytes.insert(text_bytes.size(), qtt_pkg::CHAR_MINUS);
                    n = $urandom_range(0, 6);
                    repeat (n)
                        text_bytes.insert(text_bytes.size(),
                                          ($urandom_range(0, 5) == 0) ? qtt_pkg::CHAR_DOT :
                                          CHAR_ZERO + 8'($urandom_range(0, 9)));
                end
                4:
                begin
                    text_bytes.insert(text_bytes.size(),
                                      ($urandom_range(0, 4) == 0) ? qtt_pkg::CHAR_UNDER :
                                      CHAR_LOW_A + 8'($urandom_range(0, 25)));
                    n = $urandom_range(0, 8);
                    repeat (n)
                        text_bytes.insert(text_bytes.size(), ident_char());
                end
                5, 6:
                begin
                    n = $urandom_range(1, 3);
                    repeat (n)
                        text_bytes.insert(text_bytes.size(), ($urandom_range(0, 2) == 0) ?
                                          CHAR_TAB + 8'($urandom_range(0, 4)) : CHAR_SPACE);
                end
                7:
                    text_bytes.insert(text_bytes.size(), 8'($urandom_range(0, 255)));
                default:
                    text_bytes.insert(text_bytes.size(), 8'($urandom_range(128, 255)));
            endcase
        end
        foreach (text_bytes[i])
            push_byte(text_bytes[i], i == text_bytes.size() - 1, settle && i == 0);
    endtask

    // text request driver, bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        pending_byte_t nxt;
        bit            offer;
        if (!rst_n)
        begin
            text_valid <= 1'b0;
            text_item  <= '0;
        end
        else
        begin
            if (text_valid && text_ready)
            begin
                lex_byte(text_item);
                bytes_sent++;
                if (text_item.final_byte)
                    texts_ended++;
            end
            if (!(text_valid && !text_ready))
            begin
                offer = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (text_queue.size() > 0 &&
                         !(text_queue[0].settle && lexed_tokens.size() > 0))
                begin
                    nxt   = text_queue.pop_front();
                    offer = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                text_valid <= offer;
                if (offer)
                    text_item <= nxt.item;
            end
        end
    end

    // token monitor and checker, receiver stalls by phase plus long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        qtt_pkg::token_item_t want;
        bit                   ready_next;
        if (!rst_n)
            token_ready <= 1'b0;
        else
        begin
            if (token_valid && token_ready)
            begin
                tokens_checked++;
                kinds_seen[token_item.token_kind] = 1'b1;
                if (token_item.start_offset == POS_MAX)
                    saturated_tokens++;
                if (lexed_tokens.size() == 0)
                    note_failure($sformatf("unexpected token kind %0d offset %0d length %0d last %0b",
                                           token_item.token_kind, token_item.start_offset,
                                           token_item.text_length, token_item.run_last));
                else
                begin
                    want = lexed_tokens.pop_front();
                    if (token_item.token_kind !== want.token_kind ||
                        token_item.start_offset !== want.start_offset ||
                        token_item.text_length !== want.text_length ||
                        token_item.run_last !== want.run_last)
                        note_failure($sformatf({"token %0d expected kind %0d offset %0d ",
                                                "length %0d last %0b, got kind %0d offset %0d ",
                                                "length %0d last %0b"},
                                               tokens_checked, want.token_kind,
                                               want.start_offset, want.text_length,
                                               want.run_last, token_item.token_kind,
                                               token_item.start_offset, token_item.text_length,
                                               token_item.run_last));
                end
            end

            stall_cycle++;
            if (hold_left == 0 && tokens_checked >= next_hold_at)
            begin
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + 1100;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                case ((stall_cycle >> 8) % 4)
                    0:       ready_next = 1'b1;
                    1:       ready_next = $urandom_range(0, 3) != 0;
                    2:       ready_next = $urandom_range(0, 2) == 0;
                    default: ready_next = (stall_cycle % 7) < 4;
                endcase
            end
            token_ready <= ready_next;
        end
    end

    // watchdog on cycles with no accepted request on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_valid && text_ready) || (token_valid && token_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no progress for %0d cycles", STALL_LIMIT);
                $display("FAIL query_text_tokenizer_unit");
                $finish;
            end
        end
    end

    initial
    begin
        int random_bytes;
        int n_texts;
        int queued_before;

        // directed: punctuation, strings, numbers, identifiers, odd bytes, text ends
        push_text("{}():,", 1'b0);
        push_text("\"a\"", 1'b0);
        push_text("-1.5)", 1'b0);
        push_text("_z9 ", 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_text("\"q", 1'b1);
        push_text("-", 1'b1);
        push_text("x7", 1'b1);

        // random texts, mostly short, now and then a longer one
        random_bytes = 0;
        n_texts      = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            queued_before = text_queue.size();
            add_random_text(($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) :
                            $urandom_range(1, 30), n_texts % 16 == 0);
            random_bytes += text_queue.size() - queued_before;
            n_texts++;
        end

        // reset
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all text to go in and all tokens to come out
        while (text_queue.size() > 0 || text_valid || lexed_tokens.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (lexed_tokens.size() > 0)
        begin
            note_failure($sformatf("missing token kind %0d offset %0d length %0d",
                                   lexed_tokens[0].token_kind, lexed_tokens[0].start_offset,
                                   lexed_tokens[0].text_length));
            void'(lexed_tokens.pop_front());
        end

        $display("covered %0d text bytes in %0d texts, %0d tokens of %0d kinds checked",
                 bytes_sent, texts_ended, tokens_checked, $countones(kinds_seen));
        $display("%0d tokens at saturated offset, %0d failures", saturated_tokens, failures);
        if (failures == 0)
            $display("PASS query_text_tokenizer_unit");
        else
            $display("FAIL query_text_tokenizer_unit");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/qtt_pkg.sv
hdl/qtt_lexer.sv
hdl/qtt_token_queue.sv
hdl/query_text_tokenizer_unit.sv
test/testbench.sv
